@@ rtl/core/crc32fc_pkg.sv @@
// shared types, constants and the byte-wise crc step of the crc-32 frame checker
// depends on nothing
`default_nettype none
package crc32fc_pkg;

    localparam int          DEF_PAYLOAD_BYTES = 100;
    localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;

    typedef struct packed {
        logic recv_en;
        logic rd_issue;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_good;
        logic rd_ok;
        logic rd_last;
    } t_dp_status;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/crc32_frame_checker.sv @@
// top level of the crc-32 frame checker: controller, datapath and payload ram
// depends on crc32fc_pkg, crc32fc_ctrl, crc32fc_dp
//
// input channel: i_in_valid / o_in_stall with i_data_byte, one word (byte) per
// cycle while receiving. a frame is PAYLOAD_BYTES payload bytes then a 4-byte
// check word, msb first, compared against reflected crc-32 (0xedb88320, start
// all ones, no final xor) of the payload.
// output channel: o_out_valid / i_out_stall with o_payload_word and
// o_last_word, ceil(PAYLOAD_BYTES/4) words per good frame, earliest byte in
// bits 31:24, zero padded, last marker on the final word. bad frames give none.
// after the last check byte is taken, the first word passes the controller state,
// the ram read register and the output register. after a good frame the input
// is stalled while the words are read out of the payload ram, one read in flight
// at a time, and each read also waits while the receiver stalls. a stalled output
// word holds in the output register.
// reset: synchronous active low; byte position zero, crc all ones, output empty.
// the payload ram needs no clearing, every entry is written before it is read.
`default_nettype none
module crc32_frame_checker
    import crc32fc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_payload_word,
    output logic             o_last_word
);

    t_dp_cmd    cmd;
    t_dp_status status;

    crc32fc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    crc32fc_dp #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_payload_word(o_payload_word),
        .o_last_word   (o_last_word)
    );

endmodule
`default_nettype wire

@@ rtl/core/crc32fc_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none
module crc32fc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/core/crc32fc_ctrl.sv @@
// controller: receive / drain sequencing of the frame checker
// depends on crc32fc_pkg
`default_nettype none
module crc32fc_ctrl
    import crc32fc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_in_stall
);

    localparam logic ST_RECV  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.recv_en  = 1'b0;
        o_cmd.rd_issue = 1'b0;
        unique case (r_state)
            ST_RECV: begin
                o_cmd.recv_en = 1'b1;
                if (i_status.frame_good) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.rd_issue = i_status.rd_ok;
                if (i_status.rd_ok && i_status.rd_last) begin
                    n_state = ST_RECV;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_RECV);

endmodule
`default_nettype wire

@@ rtl/core/crc32fc_dp.sv @@
// datapath: byte position, crc, check word, payload word ram and output register
// depends on crc32fc_pkg and crc32fc_ram
`default_nettype none
module crc32fc_dp
    import crc32fc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_payload_word,
    output logic             o_last_word
);

    localparam int PW       = $clog2(PAYLOAD_BYTES + 4);
    localparam int WORDS    = (PAYLOAD_BYTES + 3) / 4;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PAD_BITS = 8 * ((4 - (PAYLOAD_BYTES % 4)) % 4);
    localparam logic [PW-1:0] LAST_PAY   = PW'(PAYLOAD_BYTES - 1);
    localparam logic [PW-1:0] LAST_FRAME = PW'(PAYLOAD_BYTES + 3);
    localparam logic [PW-1:0] PAY_END    = PW'(PAYLOAD_BYTES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(WORDS - 1);

    logic [PW-1:0] r_pos;
    logic [31:0]   r_crc;
    logic [23:0]   r_acc;
    logic [31:0]   r_check;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_pend;
    logic          r_pend_last;
    logic          r_out_valid;
    logic          r_out_last;
    logic [31:0]   r_out_word;

    logic          in_acc;
    logic          is_pay;
    logic [31:0]   full_word;
    logic [31:0]   check_word;
    logic          wr_en;
    logic [31:0]   wr_data;
    logic [31:0]   rd_data;
    logic          out_take;

    assign in_acc     = i_in_valid && i_cmd.recv_en;
    assign is_pay     = (r_pos < PAY_END);
    assign full_word  = {r_acc, i_data_byte};
    assign check_word = {r_check[23:0], i_data_byte};
    assign wr_en      = in_acc && is_pay && ((r_pos[1:0] == 2'd3) || (r_pos == LAST_PAY));
    assign wr_data    = (r_pos == LAST_PAY) ? (full_word << PAD_BITS) : full_word;
    assign out_take   = r_out_valid && !i_out_stall;

    assign o_status.frame_good = in_acc && (r_pos == LAST_FRAME) && (check_word == r_crc);
    assign o_status.rd_ok      = !r_rd_pend && (!r_out_valid || !i_out_stall);
    assign o_status.rd_last    = (r_rd_addr == LAST_ADDR);

    crc32fc_ram #(
        .WIDTH(32),
        .DEPTH(WORDS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_pos[AW+1:2]),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.rd_issue),
        .i_rd_addr(r_rd_addr),
        .o_rd_data(rd_data)
    );

    // frame receive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else if (in_acc) begin
            if (is_pay) begin
                r_pos <= r_pos + PW'(1);
                r_crc <= crc32_byte(r_crc, i_data_byte);
            end else if (r_pos == LAST_FRAME) begin
                r_pos <= '0;
                r_crc <= CRC_INIT;
            end else begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (is_pay) begin
                r_acc <= full_word[23:0];
            end else begin
                r_check <= check_word;
            end
        end
    end

    // drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.rd_issue) begin
                r_rd_addr <= o_status.rd_last ? '0 : r_rd_addr + AW'(1);
                r_rd_pend <= 1'b1;
            end else if (r_rd_pend) begin
                r_rd_pend <= 1'b0;
            end
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_pend_last <= o_status.rd_last;
        end
        if (r_rd_pend) begin
            r_out_word <= rd_data;
            r_out_last <= r_pend_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_word = r_out_word;
    assign o_last_word    = r_out_last;

endmodule
`default_nettype wire
